/* hw/rtl/rssi_bias_estimator_core_assert.svh */
// Assertion macros shared by the checkers of the bias estimator.
// All of them sample on the rising edge of clk and are off while rst is high.
`ifndef RSSI_BIAS_ESTIMATOR_CORE_ASSERT_SVH
`define RSSI_BIAS_ESTIMATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rbe_pkg.sv */
`timescale 1ns / 1ps
package rbe_pkg;

  localparam int MAX_PAIRS  = 64;
  localparam int MIN_PAIRS  = 3;
  localparam int PAIR_W     = $clog2(MAX_PAIRS + 1);
  localparam int RSSI_W     = 8;
  localparam int SUM_W      = 16;
  localparam int BIAS_W     = 16;
  localparam int CNT_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 8;               // Q8.8 fraction bits of the bias
  localparam int DIV_W      = CNT_W + 1;       // dividend width of the shared divider
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int QUO_W      = GAIN_W + 1;      // both quotients fit here
  localparam int MEAN_W     = QUO_W + 1;
  localparam int MUL_W      = 17;              // shared multiplier operand width
  localparam int WG_W       = 33;              // weight * gain
  localparam int ACC_W      = 50;              // |delta| * weight * gain, plus rounding
  localparam int STEP_SHIFT = 32;
  localparam int PC_W       = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_PAIR_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_RSSI_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_GAIN      = 1'b1;

  localparam logic signed [RSSI_W-1:0] THRESHOLD_RESET = -8'sd100;
  localparam logic [GAIN_W-1:0]        GAIN_RESET      = 16'd655;
  localparam logic [DIV_W-1:0]         RECIP_ONE       = DIV_W'(65536);
  localparam logic [ACC_W-1:0]         ROUND_HALF      = ACC_W'(64'h0000_0000_8000_0000);

  typedef struct packed {
    logic signed [RSSI_W-1:0] measured_rssi;
    logic signed [RSSI_W-1:0] map_rssi;
    logic                     map_found;
    logic                     lookup_ok;
    logic [GAIN_W-1:0]        location_weight;
    logic                     last_in_scan;
  } in_item_t;

  typedef struct packed {
    logic                     success;
    logic [OUT_PAIR_W-1:0]    pair_count;
    logic signed [BIAS_W-1:0] bias_out;
    logic [CNT_W-1:0]         updates_done;
  } out_item_t;

  // Datapath actions, one per microcode step.
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_ACCUM,
    OP_CHECK,
    OP_DIV_MEAN,
    OP_GET_MEAN,
    OP_DIV_RECIP,
    OP_GET_RECIP,
    OP_MUL_WG,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_APPLY,
    OP_EMIT
  } op_t;

  // Sequencing modes of a microcode step.
  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_JMP_MORE,
    SEQ_JMP_SKIP,
    SEQ_WAIT_DIV,
    SEQ_WAIT_OUT
  } seq_t;

  typedef struct packed {
    op_t             op;
    seq_t            seq;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } dp_ctrl_t;

  typedef struct packed {
    logic in_xfer;
    logic more;
    logic skip;
    logic div_busy;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

/* hw/rtl/rbe_divider.sv */
`timescale 1ns / 1ps
module rbe_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  rbe_pkg::div_req_t         req,
  output logic                      busy,
  output logic [rbe_pkg::QUO_W-1:0] quotient
);
  import rbe_pkg::*;

  // Restoring divider, one quotient bit per cycle.
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_W-1:0]     quo;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     divisor;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_sub;
  logic                 ge;

  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign busy     = count != '0;
  assign quotient = quo[QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.start) begin
      count <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

endmodule

/* hw/rtl/rbe_sequencer.sv */
`timescale 1ns / 1ps
module rbe_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  rbe_pkg::dp_status_t status,
  output rbe_pkg::dp_ctrl_t   ctrl
);
  import rbe_pkg::*;

  localparam logic [PC_W-1:0] STEP_IDLE      = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_ACCUM     = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_CHECK     = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_DIV_MEAN  = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_GET_MEAN  = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_DIV_RECIP = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_GET_RECIP = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_MUL_WG    = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_MUL_LO    = PC_W'(8);
  localparam logic [PC_W-1:0] STEP_MUL_HI    = PC_W'(9);
  localparam logic [PC_W-1:0] STEP_APPLY     = PC_W'(10);
  localparam logic [PC_W-1:0] STEP_EMIT      = PC_W'(11);

  // Microcode program.
  function automatic uword_t rom(input logic [PC_W-1:0] addr);
    uword_t w;
    case (addr)
      STEP_IDLE:      w = '{op: OP_LOAD,      seq: SEQ_WAIT_IN,  target: STEP_IDLE};
      STEP_ACCUM:     w = '{op: OP_ACCUM,     seq: SEQ_JMP_MORE, target: STEP_IDLE};
      STEP_CHECK:     w = '{op: OP_CHECK,     seq: SEQ_JMP_SKIP, target: STEP_EMIT};
      STEP_DIV_MEAN:  w = '{op: OP_DIV_MEAN,  seq: SEQ_NEXT,     target: STEP_IDLE};
      STEP_GET_MEAN:  w = '{op: OP_GET_MEAN,  seq: SEQ_WAIT_DIV, target: STEP_IDLE};
      STEP_DIV_RECIP: w = '{op: OP_DIV_RECIP, seq: SEQ_NEXT,     target: STEP_IDLE};
      STEP_GET_RECIP: w = '{op: OP_GET_RECIP, seq: SEQ_WAIT_DIV, target: STEP_IDLE};
      STEP_MUL_WG:    w = '{op: OP_MUL_WG,    seq: SEQ_NEXT,     target: STEP_IDLE};
      STEP_MUL_LO:    w = '{op: OP_MUL_LO,    seq: SEQ_NEXT,     target: STEP_IDLE};
      STEP_MUL_HI:    w = '{op: OP_MUL_HI,    seq: SEQ_NEXT,     target: STEP_IDLE};
      STEP_APPLY:     w = '{op: OP_APPLY,     seq: SEQ_NEXT,     target: STEP_IDLE};
      STEP_EMIT:      w = '{op: OP_EMIT,      seq: SEQ_WAIT_OUT, target: STEP_IDLE};
      default:        w = '{op: OP_LOAD,      seq: SEQ_WAIT_IN,  target: STEP_IDLE};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uw;
  logic            fire;

  assign uw        = rom(pc);
  assign ctrl.op   = uw.op;
  assign ctrl.fire = fire;

  always_comb begin
    fire    = 1'b1;
    pc_next = pc + 1'b1;
    case (uw.seq)
      SEQ_NEXT: begin
        pc_next = pc + 1'b1;
      end
      SEQ_WAIT_IN: begin
        fire    = status.in_xfer;
        pc_next = status.in_xfer ? pc + 1'b1 : pc;
      end
      SEQ_JMP_MORE: begin
        pc_next = status.more ? uw.target : pc + 1'b1;
      end
      SEQ_JMP_SKIP: begin
        pc_next = status.skip ? uw.target : pc + 1'b1;
      end
      SEQ_WAIT_DIV: begin
        fire    = !status.div_busy;
        pc_next = status.div_busy ? pc : pc + 1'b1;
      end
      SEQ_WAIT_OUT: begin
        fire    = status.out_free;
        pc_next = status.out_free ? uw.target : pc;
      end
      default: begin
        pc_next = uw.target;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* hw/rtl/rbe_datapath.sv */
`timescale 1ns / 1ps
module rbe_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rbe_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rbe_pkg::out_item_t             out_item,
  input  rbe_pkg::dp_ctrl_t              ctrl,
  output rbe_pkg::dp_status_t            status
);
  import rbe_pkg::*;

  localparam int SUM_X_W = BIAS_W + 4;
  localparam logic signed [SUM_X_W-1:0] BIAS_HI = SUM_X_W'(2 ** (BIAS_W - 1) - 1);
  localparam logic signed [SUM_X_W-1:0] BIAS_LO = -SUM_X_W'(2 ** (BIAS_W - 1));

  // Configuration and architectural state.
  logic signed [RSSI_W-1:0] rssi_threshold;
  logic [GAIN_W-1:0]        bias_gain;
  logic signed [SUM_W-1:0]  diff_sum;
  logic [PAIR_W-1:0]        pairs_seen;
  logic [CNT_W-1:0]         update_counter;
  logic signed [BIAS_W-1:0] bias_value;

  // Working registers.
  in_item_t                 item;
  logic                     ok;
  logic signed [MEAN_W-1:0] mean;
  logic [QUO_W-1:0]         recip;
  logic [WG_W-1:0]          wg;
  logic [MUL_W-1:0]         delta_mag;
  logic                     delta_neg;
  logic [ACC_W-1:0]         acc;

  // Combinational.
  logic                      in_xfer;
  logic                      pair_hit;
  logic signed [RSSI_W:0]    pair_diff;
  logic [SUM_W-1:0]          sum_mag;
  logic [QUO_W-1:0]          gain_sel;
  logic signed [MEAN_W:0]    delta;
  logic [MUL_W-1:0]          mul_a;
  logic [MUL_W-1:0]          mul_b;
  logic [2*MUL_W-1:0]        prod;
  logic [ACC_W-STEP_SHIFT-1:0] step_mag;
  logic signed [SUM_X_W-1:0] bias_sum;
  logic signed [BIAS_W-1:0]  bias_next;
  logic                      skip;
  logic                      emit_fire;
  div_req_t                  div_req;
  logic                      div_busy;
  logic [QUO_W-1:0]          div_quo;

  rbe_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign in_ready = ctrl.op == OP_LOAD;
  assign in_xfer  = in_valid && in_ready;

  assign pair_hit  = ($signed(item.measured_rssi) >= rssi_threshold) && item.map_found
                     && (pairs_seen < PAIR_W'(MAX_PAIRS));
  assign pair_diff = (RSSI_W + 1)'($signed(item.map_rssi))
                     - (RSSI_W + 1)'($signed(item.measured_rssi));
  assign skip      = !item.lookup_ok || (pairs_seen < PAIR_W'(MIN_PAIRS));
  assign sum_mag   = diff_sum[SUM_W-1] ? SUM_W'(-diff_sum) : SUM_W'(diff_sum);
  assign emit_fire = ctrl.fire && (ctrl.op == OP_EMIT);

  assign status.in_xfer  = in_xfer;
  assign status.more     = !item.last_in_scan;
  assign status.skip     = skip;
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || out_ready;

  // Divider requests: rounded mean of the scan, then rounded reciprocal of the counter.
  always_comb begin
    div_req.start    = ctrl.fire && (ctrl.op == OP_DIV_MEAN || ctrl.op == OP_DIV_RECIP);
    div_req.dividend = DIV_W'({sum_mag, {FRAC_W{1'b0}}}) + DIV_W'(pairs_seen >> 1);
    div_req.divisor  = CNT_W'(pairs_seen);
    if (ctrl.op == OP_DIV_RECIP) begin
      div_req.dividend = RECIP_ONE + DIV_W'(update_counter >> 1);
      div_req.divisor  = update_counter;
    end
  end

  assign gain_sel = (recip > QUO_W'(bias_gain)) ? recip : QUO_W'(bias_gain);
  assign delta    = (MEAN_W + 1)'(mean) - (MEAN_W + 1)'(bias_value);

  // Shared 17x17 multiplier.
  always_comb begin
    case (ctrl.op)
      OP_MUL_WG: begin
        mul_a = MUL_W'(item.location_weight);
        mul_b = gain_sel;
      end
      OP_MUL_LO: begin
        mul_a = delta_mag;
        mul_b = wg[MUL_W-1:0];
      end
      OP_MUL_HI: begin
        mul_a = delta_mag;
        mul_b = MUL_W'(wg[WG_W-1:MUL_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign step_mag = acc[ACC_W-1:STEP_SHIFT];
  assign bias_sum = delta_neg ? SUM_X_W'(bias_value) - $signed(SUM_X_W'(step_mag))
                              : SUM_X_W'(bias_value) + $signed(SUM_X_W'(step_mag));
  assign bias_next = (bias_sum > BIAS_HI) ? BIAS_W'(BIAS_HI) :
                     (bias_sum < BIAS_LO) ? BIAS_W'(BIAS_LO) : BIAS_W'(bias_sum);

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rssi_threshold <= THRESHOLD_RESET;
      bias_gain      <= GAIN_RESET;
      diff_sum       <= '0;
      pairs_seen     <= '0;
      update_counter <= '0;
      bias_value     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RSSI_THRESHOLD: rssi_threshold <= cfg_data[RSSI_W-1:0];
          CFG_BIAS_GAIN:      bias_gain      <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      if (ctrl.fire) begin
        case (ctrl.op)
          OP_ACCUM: begin
            if (pair_hit) begin
              diff_sum   <= diff_sum + SUM_W'(pair_diff);
              pairs_seen <= pairs_seen + 1'b1;
            end
          end
          OP_CHECK: begin
            if (!skip && update_counter != '1) begin
              update_counter <= update_counter + 1'b1;
            end
          end
          OP_APPLY: begin
            bias_value <= bias_next;
          end
          OP_EMIT: begin
            out_valid  <= 1'b1;
            diff_sum   <= '0;
            pairs_seen <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.op)
        OP_LOAD: begin
          item <= in_item;
        end
        OP_CHECK: begin
          ok <= !skip;
        end
        OP_GET_MEAN: begin
          mean <= diff_sum[SUM_W-1] ? -$signed(MEAN_W'(div_quo)) : $signed(MEAN_W'(div_quo));
        end
        OP_GET_RECIP: begin
          recip <= div_quo;
        end
        OP_MUL_WG: begin
          wg        <= prod[WG_W-1:0];
          delta_neg <= delta < 0;
          delta_mag <= MUL_W'((delta < 0) ? -delta : delta);
        end
        OP_MUL_LO: begin
          acc <= ACC_W'(prod) + ROUND_HALF;
        end
        OP_MUL_HI: begin
          acc <= acc + (ACC_W'(prod) << MUL_W);
        end
        OP_EMIT: begin
          out_item.success      <= ok;
          out_item.pair_count   <= item.lookup_ok ? OUT_PAIR_W'(pairs_seen) : '0;
          out_item.bias_out     <= bias_value;
          out_item.updates_done <= update_counter;
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/rssi_bias_estimator_core.sv */
// An observation that does not end a scan passes the idle and accum steps before the
// next one is taken. A last observation also passes check and emit; one that updates
// adds the two passes of the shared bit-serial divider (mean, then 1/counter), which
// set the length of an updating scan end.
// Reset (rst, synchronous): threshold -100 dBm, gain 655, sums, bias and counter zero.
`timescale 1ns / 1ps
module rssi_bias_estimator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rbe_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rbe_pkg::out_item_t             out_item
);
  import rbe_pkg::*;

  // The block is a small microcoded machine. The sequencer walks a twelve-step
  // program held in a constant table; each step names one datapath action and
  // a sequencing mode (advance, wait on a condition, or jump).
  //
  // Per observation:
  //   idle    - raise in_ready, capture the item on its transfer
  //   accum   - add (map - measured) when the pair counts; jump back to idle
  //             unless this is the last item of the scan
  // At the end of a scan:
  //   check   - bump the saturating update counter, or skip straight to emit
  //             when the lookup failed or fewer than three pairs counted
  //   mean    - start the divider on |sum| * 256 + pairs/2, wait, apply sign
  //   recip   - start the divider on 65536 + counter/2, wait
  //   mul_wg  - weight * max(gain, recip); latch |mean - bias| and its sign
  //   mul_lo  - low partial product of |delta| * wg, plus the rounding half
  //   mul_hi  - add the high partial product shifted into place
  //   apply   - add or subtract the rounded step, saturate the bias
  //   emit    - load the output register once it is free, clear the scan sums
  //
  // The output register decouples the two sides: a result may sit in it
  // waiting for out_ready while the next scan's observations are taken.

  dp_ctrl_t   ctrl;
  dp_status_t status;

  rbe_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Datapath: config registers, accumulator, shared multiplier, divider
  // and the output register.
  rbe_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .ctrl      (ctrl),
    .status    (status)
  );

endmodule

/* hw/rtl/rbe_checker.sv */
`timescale 1ns / 1ps
`include "rssi_bias_estimator_core_assert.svh"
module rbe_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rbe_pkg::out_item_t out_item
);
  import rbe_pkg::*;

  // A stalled result holds.
  `RBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

  // Every observation needs at least an accumulate step after its transfer.
  `RBE_ASSERT_NEXT(a_in_cadence, in_valid && in_ready, !in_ready, "observation taken in back-to-back cycles")

  // Reported pair count never passes the cap.
  `RBE_ASSERT_SAME(a_pair_cap, out_valid, out_item.pair_count <= OUT_PAIR_W'(MAX_PAIRS), "pair count above cap")

  // An update needs at least the minimum number of pairs.
  `RBE_ASSERT_SAME(a_success_pairs, out_valid && out_item.success, out_item.pair_count >= OUT_PAIR_W'(MIN_PAIRS), "update with too few pairs")

  // An update leaves a nonzero counter.
  `RBE_ASSERT_SAME(a_success_count, out_valid && out_item.success, out_item.updates_done != '0, "update with zero counter")

endmodule

bind rssi_bias_estimator_core rbe_checker u_rbe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import rbe_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  rssi_bias_estimator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Observations waiting to be offered, and scan reports waiting to come out.
  in_item_t  obs_q[$];
  out_item_t scan_report_q[$];
  int        obs_issued   = 0;
  int        obs_accepted = 0;
  int        mismatch_count = 0;

  // Idle odds, in percent, for the sender and the receiver.
  int send_idle_pct = 13;
  int recv_idle_pct = 61;

  // Shadow copy of the estimator: registers and running state.
  logic signed [RSSI_W-1:0] model_threshold = THRESHOLD_RESET;
  logic [GAIN_W-1:0]        model_gain      = GAIN_RESET;
  int                       diff_acc        = 0;
  int                       pairs_acc       = 0;
  logic [CNT_W-1:0]         update_total    = '0;
  logic signed [BIAS_W-1:0] bias_est        = '0;

  // Fold one accepted observation into the shadow state; on the last one of a
  // scan, push the report that the block must produce.
  function automatic void absorb_observation(input in_item_t obs);
    out_item_t         rep;
    longint            scaled;
    longint            mean;
    longint            delta;
    longint            nudged;
    longint unsigned   mag;
    longint unsigned   recip;
    longint unsigned   g;
    longint unsigned   wg;
    bit                neg;
    if (obs.measured_rssi >= model_threshold && obs.map_found && pairs_acc < MAX_PAIRS) begin
      diff_acc  += int'(obs.map_rssi) - int'(obs.measured_rssi);
      pairs_acc += 1;
    end
    if (!obs.last_in_scan) return;

    rep = '0;
    if (obs.lookup_ok) begin
      rep.pair_count = pairs_acc[OUT_PAIR_W-1:0];
      if (pairs_acc >= MIN_PAIRS) begin
        rep.success = 1'b1;
        if (update_total != 32'hFFFF_FFFF) update_total += 1;
        // Mean difference in Q8.8, rounded half away from zero.
        scaled = longint'(diff_acc) * 256;
        neg    = scaled < 0;
        mag    = neg ? longint'(-scaled) : scaled;
        mag    = (mag + longint'(pairs_acc / 2)) / longint'(pairs_acc);
        mean   = neg ? -longint'(mag) : longint'(mag);
        // Gain floor of 1/counter keeps early updates fast.
        recip  = (64'd65536 + longint'(update_total) / 2) / longint'(update_total);
        g      = (longint'(model_gain) > recip) ? longint'(model_gain) : recip;
        wg     = longint'(obs.location_weight) * g;
        delta  = mean - longint'(bias_est);
        neg    = delta < 0;
        mag    = neg ? longint'(-delta) : delta;
        mag    = (mag * wg + 64'h8000_0000) >> 32;
        nudged = longint'(bias_est) + (neg ? -longint'(mag) : longint'(mag));
        if (nudged > 32767) nudged = 32767;
        if (nudged < -32768) nudged = -32768;
        bias_est = nudged[BIAS_W-1:0];
      end
    end
    rep.bias_out     = bias_est;
    rep.updates_done = update_total;
    scan_report_q.push_back(rep);
    diff_acc  = 0;
    pairs_acc = 0;
  endfunction

  // Driver: offer the next pending observation once the previous transfer is done.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_observation(in_item);
        obs_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (obs_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= obs_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every report transfer against the oldest prediction.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (scan_report_q.size() == 0) begin
          $display("%0t: unexpected report success=%0b pairs=%0d bias=%0d updates=%0d",
                   $time, out_item.success, out_item.pair_count, out_item.bias_out,
                   out_item.updates_done);
          mismatch_count++;
        end else begin
          want = scan_report_q.pop_front();
          if (out_item !== want) begin
            $display("%0t: report mismatch expected success=%0b pairs=%0d bias=%0d updates=%0d",
                     $time, want.success, want.pair_count, want.bias_out, want.updates_done);
            $display("%0t:                 actual success=%0b pairs=%0d bias=%0d updates=%0d",
                     $time, out_item.success, out_item.pair_count, out_item.bias_out,
                     out_item.updates_done);
            mismatch_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [RSSI_W-1:0] clamp_rssi(input int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return v[RSSI_W-1:0];
  endfunction

  task automatic queue_obs(input int meas, input int map, input bit found, input bit lookup,
                           input int weight, input bit last);
    in_item_t obs;
    obs.measured_rssi   = clamp_rssi(meas);
    obs.map_rssi        = clamp_rssi(map);
    obs.map_found       = found;
    obs.lookup_ok       = lookup;
    obs.location_weight = weight[GAIN_W-1:0];
    obs.last_in_scan    = last;
    obs_q.push_back(obs);
    obs_issued++;
  endtask

  // Queue random scans until about n_items observations are pending. Most scans
  // are well formed (lookup ok, enough pairs); some are short, failed or oversized.
  task automatic queue_random_scans(input int n_items);
    int queued;
    int len;
    int r;
    int mode;
    int thr;
    int meas;
    int map;
    int weight;
    bit lookup;
    queued = 0;
    while (queued < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) len = $urandom_range(1, 2);
      else if (r < 94) len = $urandom_range(3, 12);
      else len = $urandom_range(60, 72);
      lookup = ($urandom_range(0, 9) != 0);
      r = $urandom_range(0, 9);
      mode = (r < 8) ? 0 : r - 7;
      thr = int'(model_threshold);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 9);
        if (r < 7) meas = thr + int'($urandom_range(0, 50));
        else if (r < 9) meas = thr - int'($urandom_range(1, 30));
        else meas = int'($urandom_range(0, 255)) - 128;
        if ($urandom_range(0, 9) < 7) map = meas + int'($urandom_range(0, 40)) - 20;
        else map = int'($urandom_range(0, 255)) - 128;
        // Drive the difference to its extremes to push the bias into saturation.
        if (mode == 1) begin
          meas = thr;
          map  = 127;
        end else if (mode == 2) begin
          meas = 127;
          map  = -128;
        end
        r = $urandom_range(0, 9);
        if (r == 0) weight = 0;
        else if (r == 1) weight = 65535;
        else weight = $urandom_range(0, 65535);
        queue_obs(meas, map, ($urandom_range(0, 9) != 0),
                  (k == len - 1) ? lookup : bit'($urandom_range(0, 1)), weight, k == len - 1);
      end
      queued += len;
    end
  endtask

  // Hold until every observation went through and every report came out, then
  // let the block settle.
  task automatic drain();
    do @(posedge clk);
    while (!(obs_accepted == obs_issued && scan_report_q.size() == 0));
    repeat (20) @(posedge clk);
  endtask

  task automatic program_regs(input logic signed [RSSI_W-1:0] thr, input logic [GAIN_W-1:0] gain);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RSSI_THRESHOLD;
    cfg_data  <= {8'($urandom_range(0, 255)), thr};
    @(posedge clk);
    cfg_index <= CFG_BIAS_GAIN;
    cfg_data  <= gain;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_threshold = thr;
    model_gain      = gain;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Largest positive difference, with pairs below threshold and missing from the map.
    queue_obs(-128, 127, 1, 0, 0, 0);
    queue_obs(127, -128, 0, 1, 65535, 0);
    queue_obs(-100, 127, 1, 0, 123, 0);
    queue_obs(-100, 127, 1, 1, 0, 0);
    queue_obs(-100, 127, 1, 1, 65535, 1);
    // Lookup failed.
    queue_obs(-50, -40, 1, 1, 0, 0);
    queue_obs(-60, -70, 1, 0, 0, 0);
    queue_obs(-45, -45, 1, 0, 65535, 1);
    // Fewer than three pairs.
    queue_obs(-80, -70, 1, 0, 0, 0);
    queue_obs(-90, -75, 1, 1, 40000, 1);
    // Largest negative difference.
    queue_obs(127, -128, 1, 0, 0, 0);
    queue_obs(127, -128, 1, 1, 0, 0);
    queue_obs(127, -128, 1, 0, 0, 0);
    queue_obs(127, -128, 1, 1, 65535, 1);
    // Zero location weight: update counts but the bias holds.
    queue_obs(-70, -60, 1, 0, 0, 0);
    queue_obs(-71, -60, 1, 0, 0, 0);
    queue_obs(-72, -59, 1, 1, 0, 1);
    // Last observation below threshold does not count.
    queue_obs(-30, -20, 1, 0, 0, 0);
    queue_obs(-31, -25, 1, 0, 0, 0);
    queue_obs(-40, -50, 1, 0, 0, 0);
    queue_obs(-101, -20, 1, 1, 32768, 1);
    queue_random_scans(340);
    drain();

    program_regs(-8'sd128, 16'hFFFF);
    queue_random_scans(340);
    drain();

    send_idle_pct = 61;
    recv_idle_pct = 13;
    program_regs(8'sd127, 16'h0000);
    queue_random_scans(300);
    drain();

    program_regs(clamp_rssi(int'($urandom_range(0, 60)) - 90), 16'($urandom_range(0, 65535)));
    queue_random_scans(340);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(clamp_rssi(int'($urandom_range(0, 60)) - 90), 16'($urandom_range(0, 4000)));
    queue_random_scans(400);
    drain();
    repeat (100) @(posedge clk);

    if (mismatch_count == 0 && scan_report_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is far shorter than this.
  initial begin
    #1_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
